@@ sv/hkt_pkg.sv @@
package hkt_pkg;

    localparam int CODE_W      = 8;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int COUNT_W     = 3;
    localparam int ACTION_W    = 2;
    localparam int INPUT_KEYS  = 6;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_REPORT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP    = 2'd3;

    // result kinds
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 2'd1;

    localparam logic [CFG_W-1:0] RESET_REPEAT_DELAY  = 16'd500;
    localparam logic [CFG_W-1:0] RESET_REPEAT_PERIOD = 16'd70;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RELEASE,
        ST_ASSIGN,
        ST_FLUSH,
        ST_TICK,
        ST_QUERY
    } hkt_state_t;

    // sequencer -> slot bank
    typedef struct packed {
        logic seen_clear;
        logic seen_acc;
        logic release_apply;
        logic assign_wr;
        logic deadline_wr;
    } hkt_slot_cmd_t;

    // slot bank -> sequencer
    typedef struct packed {
        logic known;
        logic free_ok;
        logic repeat_due;
    } hkt_slot_status_t;

endpackage

@@ sv/hkt_if.sv @@
interface hkt_req_if;
    import hkt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [TIME_W-1:0]     time_ms;
    logic [CODE_W-1:0]     modifier_bits;
    logic [COUNT_W-1:0]    key_count;
    logic [CODE_W-1:0]     key_a;
    logic [CODE_W-1:0]     key_b;
    logic [CODE_W-1:0]     key_c;
    logic [CODE_W-1:0]     key_d;
    logic [CODE_W-1:0]     key_e;
    logic [CODE_W-1:0]     key_f;

    modport source (
        output valid, action, time_ms, modifier_bits, key_count,
               key_a, key_b, key_c, key_d, key_e, key_f,
        input  ready
    );
    modport sink (
        input  valid, action, time_ms, modifier_bits, key_count,
               key_a, key_b, key_c, key_d, key_e, key_f,
        output ready
    );
endinterface

interface hkt_rsp_if;
    import hkt_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [CODE_W-1:0] event_code;
    logic [CODE_W-1:0] event_modifiers;
    logic              is_down;
    logic              last;

    modport source (
        output valid, kind, event_code, event_modifiers, is_down, last,
        input  ready
    );
    modport sink (
        input  valid, kind, event_code, event_modifiers, is_down, last,
        output ready
    );
endinterface

interface hkt_cfg_if;
    import hkt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

@@ sv/hkt_slot_bank.sv @@
module hkt_slot_bank #(
    parameter int SLOTS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hkt_pkg::hkt_slot_cmd_t        cmd,
    input  logic [hkt_pkg::CODE_W-1:0]    key,
    input  logic [hkt_pkg::CODE_W-1:0]    mods,
    input  logic [hkt_pkg::TIME_W-1:0]    now,
    input  logic [hkt_pkg::CFG_W-1:0]     addend,
    output hkt_pkg::hkt_slot_status_t     status,
    output logic [hkt_pkg::CODE_W-1:0]    rec_code,
    output logic [hkt_pkg::CODE_W-1:0]    rec_mods
);
    import hkt_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0]  active_reg;
    logic [SLOTS-1:0]  seen_reg;
    logic [SLOTS-1:0]  seen_next;
    logic [SLOTS-1:0]  match;
    logic [SLOT_W-1:0] recent_reg;
    logic [SLOT_W-1:0] free_idx;
    logic              free_ok;
    logic [TIME_W-1:0] sum;

    logic [CODE_W-1:0] code_reg     [SLOTS];
    logic [CODE_W-1:0] mods_reg     [SLOTS];
    logic [TIME_W-1:0] deadline_reg [SLOTS];

    // one lane per slot: code compare against the key under test
    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            match[s] = (code_reg[s] == key);
        end
    end

    // highest inactive slot wins
    always_comb
    begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (!active_reg[s])
            begin
                free_ok  = 1'b1;
                free_idx = SLOT_W'(s);
            end
        end
    end

    // shared deadline adder: now + delay on press, now + period on repeat
    assign sum = now + TIME_W'(addend);

    assign seen_next = cmd.seen_acc ? (seen_reg | match) : seen_reg;

    always_comb
    begin
        status.known      = |(active_reg & match);
        status.free_ok    = free_ok;
        status.repeat_due = active_reg[recent_reg] && (now > deadline_reg[recent_reg]);
    end

    assign rec_code = code_reg[recent_reg];
    assign rec_mods = mods_reg[recent_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            seen_reg   <= '0;
            recent_reg <= '0;
        end
        else
        begin
            if (cmd.seen_clear)
            begin
                seen_reg <= '0;
            end
            else
            begin
                seen_reg <= seen_next;
            end

            if (cmd.release_apply)
            begin
                active_reg <= active_reg & seen_next;
            end
            else if (cmd.assign_wr)
            begin
                active_reg[free_idx] <= 1'b1;
            end

            if (cmd.assign_wr)
            begin
                recent_reg <= free_idx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.assign_wr)
        begin
            code_reg[free_idx]     <= key;
            mods_reg[free_idx]     <= mods;
            deadline_reg[free_idx] <= sum;
        end
        else if (cmd.deadline_wr)
        begin
            deadline_reg[recent_reg] <= sum;
        end
    end

endmodule

@@ sv/hid_key_tracker_autorepeat_core.sv @@
// Channel  Role    Transaction carries
// -------  ------  ---------------------------------------------------------------
// req      sink    action, time_ms, modifier_bits, key_count, key_a..key_f
// rsp      source  kind, event_code, event_modifiers, is_down, last
// cfg      sink    reg_index, data (repeat_delay_ms, repeat_period_ms)
//
// Report: key_count is clamped to REPORT_KEYS; the key walk steps one report code per
//   cycle through the slot comparators, once to release and once to assign, and the
//   assign walk holds while a second press waits for a full output to drain.
// Action 3: no result.
// rsp back-pressure stalls the sequencer only when a result has to be written.
// rst_n clears slots, recent slot, down map, config (500 / 70) and handshake state.
// req is not ready until the current item has issued all of its results.
module hid_key_tracker_autorepeat_core #(
    parameter int SLOTS       = 8,
    parameter int REPORT_KEYS = 6
) (
    input  logic      clk,
    input  logic      rst_n,
    hkt_req_if.sink   req,
    hkt_rsp_if.source rsp,
    hkt_cfg_if.sink   cfg
);
    import hkt_pkg::*;

    localparam int KEY_W = (REPORT_KEYS > 1) ? $clog2(REPORT_KEYS) : 1;

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    hkt_state_t         state_reg, state_next;
    logic [KEY_W-1:0]   key_idx_reg, key_idx_next;

    // The down map is the latest report's code list: a code is down when it
    // is nonzero and appears among the first map_count codes.
    logic [CODE_W-1:0]  map_keys_reg [REPORT_KEYS];
    logic [COUNT_W-1:0] map_count_reg;

    logic [TIME_W-1:0]  now_reg;
    logic [CODE_W-1:0]  mods_reg;
    logic [CODE_W-1:0]  qkey_reg;

    // press event held back until we know whether it is the last one
    logic               pend_valid_reg;
    logic [CODE_W-1:0]  pend_code_reg;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [CODE_W-1:0]  out_code_reg;
    logic [CODE_W-1:0]  out_mods_reg;
    logic               out_down_reg;
    logic               out_last_reg;

    logic [CFG_W-1:0]   delay_reg;
    logic [CFG_W-1:0]   period_reg;

    // ---------------------------------------------------------------------
    // Datapath helpers
    // ---------------------------------------------------------------------
    logic [CODE_W-1:0]  rpt_in [INPUT_KEYS];
    logic [COUNT_W-1:0] count_clamped;
    logic               accept;
    logic               out_free;
    logic [CODE_W-1:0]  key_cur;
    logic               key_in_range;
    logic               last_key;
    logic               new_event;
    logic               step_ok;
    logic               query_hit;
    logic               query_down;

    hkt_slot_cmd_t      cmd;
    hkt_slot_status_t   status;
    logic [CODE_W-1:0]  rec_code;
    logic [CODE_W-1:0]  rec_mods;
    logic [CFG_W-1:0]   addend;

    // outputs of the control decode
    logic               req_ready;
    logic               load_out;
    logic               ld_kind;
    logic [CODE_W-1:0]  ld_code;
    logic [CODE_W-1:0]  ld_mods;
    logic               ld_down;
    logic               ld_last;
    logic               pend_set;
    logic               pend_clr;
    logic               use_period;

    assign rpt_in[0] = req.key_a;
    assign rpt_in[1] = req.key_b;
    assign rpt_in[2] = req.key_c;
    assign rpt_in[3] = req.key_d;
    assign rpt_in[4] = req.key_e;
    assign rpt_in[5] = req.key_f;

    assign count_clamped = (req.key_count > COUNT_W'(REPORT_KEYS)) ?
                           COUNT_W'(REPORT_KEYS) : req.key_count;

    assign accept   = req.valid && req_ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign key_cur      = map_keys_reg[key_idx_reg];
    assign key_in_range = COUNT_W'(key_idx_reg) < map_count_reg;
    assign last_key     = ({1'b0, COUNT_W'(key_idx_reg)} + 4'd1) >= {1'b0, map_count_reg};

    // new code, not held by an active slot, and a slot is free
    assign new_event = key_in_range && (key_cur != '0) && !status.known && status.free_ok;
    // only a second event with the output still full has to wait
    assign step_ok   = !(new_event && pend_valid_reg && !out_free);

    always_comb
    begin
        query_hit = 1'b0;
        for (int j = 0; j < REPORT_KEYS; j++)
        begin
            if ((COUNT_W'(j) < map_count_reg) && (map_keys_reg[j] == qkey_reg))
            begin
                query_hit = 1'b1;
            end
        end
    end
    assign query_down = query_hit && (qkey_reg != '0);

    assign addend = use_period ? period_reg : delay_reg;

    hkt_slot_bank #(
        .SLOTS (SLOTS)
    ) u_slot_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .key      (key_cur),
        .mods     (mods_reg),
        .now      (now_reg),
        .addend   (addend),
        .status   (status),
        .rec_code (rec_code),
        .rec_mods (rec_mods)
    );

    // ---------------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.action)
                        ACT_REPORT: state_next = ST_RELEASE;
                        ACT_TICK:   state_next = ST_TICK;
                        ACT_QUERY:  state_next = ST_QUERY;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RELEASE:
            begin
                if (last_key)
                begin
                    state_next = ST_ASSIGN;
                end
            end
            ST_ASSIGN:
            begin
                if (step_ok && last_key)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (!status.repeat_due || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QUERY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer: control decode
    // ---------------------------------------------------------------------
    always_comb
    begin
        req_ready    = 1'b0;
        cmd          = '0;
        load_out     = 1'b0;
        ld_kind      = KIND_EVENT;
        ld_code      = '0;
        ld_mods      = '0;
        ld_down      = 1'b0;
        ld_last      = 1'b0;
        pend_set     = 1'b0;
        pend_clr     = 1'b0;
        use_period   = 1'b0;
        key_idx_next = key_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready      = 1'b1;
                cmd.seen_clear = 1'b1;
                key_idx_next   = '0;
            end
            ST_RELEASE:
            begin
                // mark every slot whose code matches this report code
                cmd.seen_acc = key_in_range;
                if (last_key)
                begin
                    cmd.release_apply = 1'b1;
                    key_idx_next      = '0;
                end
                else
                begin
                    key_idx_next = key_idx_reg + KEY_W'(1);
                end
            end
            ST_ASSIGN:
            begin
                if (step_ok)
                begin
                    key_idx_next = key_idx_reg + KEY_W'(1);
                    if (new_event)
                    begin
                        cmd.assign_wr = 1'b1;
                        pend_set      = 1'b1;
                        if (pend_valid_reg)
                        begin
                            // older press goes out; a newer one follows it
                            load_out = 1'b1;
                            ld_code  = pend_code_reg;
                            ld_mods  = mods_reg;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    load_out = 1'b1;
                    ld_code  = pend_code_reg;
                    ld_mods  = mods_reg;
                    ld_last  = 1'b1;
                    pend_clr = 1'b1;
                end
            end
            ST_TICK:
            begin
                use_period = 1'b1;
                if (status.repeat_due && out_free)
                begin
                    load_out        = 1'b1;
                    ld_code         = rec_code;
                    ld_mods         = rec_mods;
                    ld_last         = 1'b1;
                    cmd.deadline_wr = 1'b1;
                end
            end
            ST_QUERY:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    ld_kind  = KIND_QUERY;
                    ld_code  = qkey_reg;
                    ld_down  = query_down;
                    ld_last  = 1'b1;
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key_idx_reg    <= '0;
            map_count_reg  <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            delay_reg      <= RESET_REPEAT_DELAY;
            period_reg     <= RESET_REPEAT_PERIOD;
        end
        else
        begin
            state_reg   <= state_next;
            key_idx_reg <= key_idx_next;

            if (accept && (req.action == ACT_REPORT))
            begin
                map_count_reg <= count_clamped;
            end

            if (pend_set)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_clr)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg.valid)
            begin
                unique case (cfg.reg_index)
                    CFG_REPEAT_DELAY:  delay_reg  <= cfg.data;
                    CFG_REPEAT_PERIOD: period_reg <= cfg.data;
                    default:           delay_reg  <= delay_reg;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg  <= req.time_ms;
            mods_reg <= req.modifier_bits;
            qkey_reg <= req.key_a;
            if (req.action == ACT_REPORT)
            begin
                for (int j = 0; j < REPORT_KEYS; j++)
                begin
                    map_keys_reg[j] <= rpt_in[j];
                end
            end
        end

        if (pend_set)
        begin
            pend_code_reg <= key_cur;
        end

        if (load_out)
        begin
            out_kind_reg <= ld_kind;
            out_code_reg <= ld_code;
            out_mods_reg <= ld_mods;
            out_down_reg <= ld_down;
            out_last_reg <= ld_last;
        end
    end

    // ---------------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------------
    assign req.ready           = req_ready;
    assign cfg.ready           = 1'b1;
    assign rsp.valid           = out_valid_reg;
    assign rsp.kind            = out_kind_reg;
    assign rsp.event_code      = out_code_reg;
    assign rsp.event_modifiers = out_mods_reg;
    assign rsp.is_down         = out_down_reg;
    assign rsp.last            = out_last_reg;

endmodule

@@ sv/hkt_checker.sv @@
module hkt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic [hkt_pkg::ACTION_W-1:0]   req_action,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic                           rsp_kind,
    input logic [hkt_pkg::CODE_W-1:0]     rsp_event_code,
    input logic [hkt_pkg::CODE_W-1:0]     rsp_event_modifiers,
    input logic                           rsp_is_down,
    input logic                           rsp_last
);
    import hkt_pkg::*;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
            && $stable(rsp_event_code) && $stable(rsp_event_modifiers)
            && $stable(rsp_is_down) && $stable(rsp_last))
        else $error("rsp changed while stalled");

    // an accepted real item drops req ready until the block is idle again
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_action != ACT_NOP) |=> !req_ready)
        else $error("req ready right after accepting an item");

    // a query answer is always alone, carries no modifiers, and code zero is never down
    a_query_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_QUERY) |->
            rsp_last && (rsp_event_modifiers == '0)
            && ((rsp_event_code != '0) || !rsp_is_down))
        else $error("malformed query answer");

    // press and repeat events come from slots, which never hold code zero
    a_event_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_EVENT) |-> !rsp_is_down && (rsp_event_code != '0))
        else $error("malformed key event");

endmodule

bind hid_key_tracker_autorepeat_core hkt_checker u_hkt_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .req_action          (req.action),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_kind            (rsp.kind),
    .rsp_event_code      (rsp.event_code),
    .rsp_event_modifiers (rsp.event_modifiers),
    .rsp_is_down         (rsp.is_down),
    .rsp_last            (rsp.last)
);

@@ tb/hkt_event_monitor.sv @@
module hkt_event_monitor #(
    parameter int SLOTS       = 8,
    parameter int REPORT_KEYS = 6
) (
    input  logic clk,
    input  logic rst_n,
    hkt_req_if   req,
    hkt_rsp_if   rsp,
    hkt_cfg_if   cfg,
    output int   pending,
    output int   failures
);
    timeunit 1ns;
    timeprecision 1ps;
    import hkt_pkg::*;

    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic              kind;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] mods;
        logic              down;
        logic              last;
    } hkt_result_t;

    // events and query answers still owed by the block, oldest first
    hkt_result_t awaited_events[$];

    // tracker state
    logic              slot_live [SLOTS];
    logic [CODE_W-1:0] slot_key  [SLOTS];
    logic [CODE_W-1:0] slot_mod  [SLOTS];
    logic [TIME_W-1:0] slot_due  [SLOTS];
    int unsigned       latest_slot;
    logic [(1<<CODE_W)-1:0] keys_down;
    logic [CFG_W-1:0]  delay_ms;
    logic [CFG_W-1:0]  period_ms;
    int                fail_total;

    task automatic track_item(
        input logic [ACTION_W-1:0]                 act,
        input logic [TIME_W-1:0]                   now,
        input logic [CODE_W-1:0]                   mods,
        input logic [COUNT_W-1:0]                  cnt,
        input logic [INPUT_KEYS-1:0][CODE_W-1:0]   keys
    );
        int          used;
        int          free_slot;
        int          n;
        logic        present;
        logic        known;
        hkt_result_t made [INPUT_KEYS];
        n = 0;
        case (act)
            ACT_REPORT: begin
                used = (int'(cnt) > REPORT_KEYS) ? REPORT_KEYS : int'(cnt);
                // drop slots whose key left the report
                for (int s = 0; s < SLOTS; s++) begin
                    if (slot_live[s]) begin
                        present = 1'b0;
                        for (int j = 0; j < used; j++)
                            if (keys[j] == slot_key[s])
                                present = 1'b1;
                        if (!present)
                            slot_live[s] = 1'b0;
                    end
                end
                // new codes take the highest free slot
                for (int j = 0; j < used; j++) begin
                    if (keys[j] == '0)
                        continue;
                    known = 1'b0;
                    free_slot = -1;
                    for (int s = 0; s < SLOTS; s++)
                        if (slot_live[s] && slot_key[s] == keys[j])
                            known = 1'b1;
                    if (known)
                        continue;
                    for (int s = 0; s < SLOTS; s++)
                        if (!slot_live[s])
                            free_slot = s;
                    if (free_slot < 0)
                        continue;
                    slot_key[free_slot]  = keys[j];
                    slot_live[free_slot] = 1'b1;
                    slot_mod[free_slot]  = mods;
                    slot_due[free_slot]  = now + TIME_W'(delay_ms);
                    latest_slot = free_slot;
                    made[n] = '{KIND_EVENT, keys[j], mods, 1'b0, 1'b0};
                    n++;
                end
                keys_down = '0;
                for (int j = 0; j < used; j++)
                    if (keys[j] != '0)
                        keys_down[keys[j]] = 1'b1;
            end
            ACT_TICK: begin
                if (latest_slot < SLOTS && slot_live[latest_slot]
                    && now > slot_due[latest_slot]) begin
                    made[n] = '{KIND_EVENT, slot_key[latest_slot],
                                slot_mod[latest_slot], 1'b0, 1'b0};
                    n++;
                    slot_due[latest_slot] = now + TIME_W'(period_ms);
                end
            end
            ACT_QUERY: begin
                made[n] = '{KIND_QUERY, keys[0], '0, keys_down[keys[0]], 1'b0};
                n++;
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++) begin
            made[i].last = (i == n - 1);
            awaited_events.push_back(made[i]);
        end
    endtask

    task automatic compare_result(input hkt_result_t got);
        hkt_result_t want;
        if (awaited_events.size() == 0) begin
            if (fail_total < MAX_SHOWN)
                $display("%0t: unexpected result kind=%0d code=%02h mods=%02h down=%0d last=%0d",
                         $realtime, got.kind, got.code, got.mods, got.down, got.last);
            fail_total++;
        end else begin
            want = awaited_events.pop_front();
            if (got.kind !== want.kind || got.code !== want.code || got.mods !== want.mods
                || got.down !== want.down || got.last !== want.last) begin
                if (fail_total < MAX_SHOWN)
                    $display("%0t: mismatch exp kind=%0d code=%02h mods=%02h down=%0d last=%0d, got kind=%0d code=%02h mods=%02h down=%0d last=%0d",
                             $realtime, want.kind, want.code, want.mods, want.down,
                             want.last, got.kind, got.code, got.mods, got.down, got.last);
                fail_total++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                slot_live[s] = 1'b0;
                slot_key[s]  = '0;
                slot_mod[s]  = '0;
                slot_due[s]  = '0;
            end
            latest_slot = 0;
            keys_down   = '0;
            delay_ms    = RESET_REPEAT_DELAY;
            period_ms   = RESET_REPEAT_PERIOD;
            awaited_events.delete();
            fail_total  = 0;
            pending  <= 0;
            failures <= 0;
        end else begin
            if (rsp.valid && rsp.ready)
                compare_result('{rsp.kind, rsp.event_code, rsp.event_modifiers,
                                 rsp.is_down, rsp.last});
            if (cfg.valid && cfg.ready) begin
                if (cfg.reg_index == CFG_REPEAT_DELAY)
                    delay_ms = cfg.data;
                else if (cfg.reg_index == CFG_REPEAT_PERIOD)
                    period_ms = cfg.data;
            end
            if (req.valid && req.ready)
                track_item(req.action, req.time_ms, req.modifier_bits, req.key_count,
                           {req.key_f, req.key_e, req.key_d, req.key_c, req.key_b, req.key_a});
            pending  <= awaited_events.size();
            failures <= fail_total;
        end
    end

endmodule

@@ tb/tb_hid_key_tracker_autorepeat_core.sv @@
module tb_hid_key_tracker_autorepeat_core;
    timeunit 1ns;
    timeprecision 1ps;
    import hkt_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 12;
    // settle time covers a report walking up to six codes twice
    localparam int SETTLE_CYCLES = 24;
    // cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 56;

    // one request transaction; keys[0] is key_a
    typedef struct packed {
        logic [ACTION_W-1:0]               action;
        logic [TIME_W-1:0]                 time_ms;
        logic [CODE_W-1:0]                 mods;
        logic [COUNT_W-1:0]                count;
        logic [INPUT_KEYS-1:0][CODE_W-1:0] keys;
    } hkt_item_t;

    logic clk = 1'b0;
    logic rst_n;

    hkt_req_if req_ch ();
    hkt_rsp_if rsp_ch ();
    hkt_cfg_if cfg_ch ();

    int pending;
    int failures;

    // pacing knobs, changed between phases
    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    logic sink_ready     = 1'b0;
    int   idle_cycles    = 0;

    // typing session state used to build well-formed reports
    logic [CODE_W-1:0] held[$];
    logic [CODE_W-1:0] held_mods = '0;
    logic [TIME_W-1:0] clock_ms  = '0;
    int unsigned       cur_delay  = 32'(RESET_REPEAT_DELAY);
    int unsigned       cur_period = 32'(RESET_REPEAT_PERIOD);

    always #(CLK_PERIOD / 2) clk = ~clk;

    hid_key_tracker_autorepeat_core #(
        .SLOTS       (8),
        .REPORT_KEYS (6)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // predicts and compares every result; hands back what is owed and what failed
    hkt_event_monitor #(
        .SLOTS       (8),
        .REPORT_KEYS (6)
    ) event_mon (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg      (cfg_ch),
        .pending  (pending),
        .failures (failures)
    );

    // result receiver: random back-pressure at the current stall rate
    assign rsp_ch.ready = sink_ready;
    always @(posedge clk)
        sink_ready <= ($urandom_range(99) >= sink_stall_pct);

    // watchdog: any transaction on any channel restarts the count
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic hkt_item_t pack_item(
        input logic [ACTION_W-1:0]               act,
        input logic [TIME_W-1:0]                 now,
        input logic [CODE_W-1:0]                 mods,
        input logic [COUNT_W-1:0]                cnt,
        input logic [INPUT_KEYS-1:0][CODE_W-1:0] keys
    );
        hkt_item_t it;
        it.action  = act;
        it.time_ms = now;
        it.mods    = mods;
        it.count   = cnt;
        it.keys    = keys;
        return it;
    endfunction

    // Present one transaction, with random idle cycles ahead of it. valid stays
    // high on return so back-to-back transactions need no extra edge.
    task automatic send_item(input hkt_item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.action        <= it.action;
        req_ch.time_ms       <= it.time_ms;
        req_ch.modifier_bits <= it.mods;
        req_ch.key_count     <= it.count;
        req_ch.key_a         <= it.keys[0];
        req_ch.key_b         <= it.keys[1];
        req_ch.key_c         <= it.keys[2];
        req_ch.key_d         <= it.keys[3];
        req_ch.key_e         <= it.keys[4];
        req_ch.key_f         <= it.keys[5];
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Stop sending, wait for every owed result, then give an item with no
    // result time to finish its walk.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called while idle. valid stays high across both writes.
    task automatic write_config(input logic [CFG_W-1:0] delay, input logic [CFG_W-1:0] period);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= CFG_REPEAT_DELAY;
        cfg_ch.data      <= delay;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.reg_index <= CFG_REPEAT_PERIOD;
        cfg_ch.data      <= period;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_delay  = 32'(delay);
        cur_period = 32'(period);
    endtask

    // Time steps: up to 3 ms, up to one repeat period plus 2, or up to the first delay
    // plus 2, so ticks land on both sides of the deadlines.
    function automatic void advance_clock();
        case ($urandom_range(2))
            0:       clock_ms += $urandom_range(3);
            1:       clock_ms += $urandom_range(cur_period + 2);
            default: clock_ms += $urandom_range(cur_delay + 2);
        endcase
    endfunction

    // Mostly a typing session: keys go down and up one at a time, ticks follow
    // the clock, queries look at held keys. The rest is raw noise.
    function automatic hkt_item_t next_random_item();
        hkt_item_t         it;
        int                pick;
        int                n;
        logic [CODE_W-1:0] code;
        logic              fresh;
        pick       = $urandom_range(99);
        it.action  = ACT_TICK;
        it.time_ms = clock_ms;
        it.mods    = CODE_W'($urandom());
        it.count   = COUNT_W'($urandom());
        it.keys    = (INPUT_KEYS * CODE_W)'({$urandom(), $urandom()});
        if (pick < 40) begin
            case ($urandom_range(2))
                0: if (held.size() < INPUT_KEYS) begin
                    code  = CODE_W'($urandom_range(255, 1));
                    fresh = 1'b1;
                    foreach (held[i])
                        if (held[i] == code)
                            fresh = 1'b0;
                    if (fresh)
                        held.push_back(code);
                end
                1: if (held.size() > 0)
                    held.delete($urandom_range(held.size() - 1));
                default: ;
            endcase
            if ($urandom_range(3) == 0)
                held_mods = CODE_W'($urandom());
            advance_clock();
            n          = held.size();
            it.action  = ACT_REPORT;
            it.time_ms = clock_ms;
            it.mods    = held_mods;
            it.keys    = '0;
            foreach (held[i])
                it.keys[i] = held[i];
            it.count = COUNT_W'($urandom_range(INPUT_KEYS, n));
            // same code twice in one report now and then
            if (n > 0 && n < INPUT_KEYS && $urandom_range(7) == 0) begin
                it.keys[n] = held[0];
                it.count   = COUNT_W'(INPUT_KEYS);
            end
        end else if (pick < 70) begin
            advance_clock();
            it.action  = ACT_TICK;
            it.time_ms = clock_ms;
        end else if (pick < 85) begin
            it.action = ACT_QUERY;
            if (held.size() > 0 && $urandom_range(1) == 1)
                it.keys[0] = held[$urandom_range(held.size() - 1)];
        end else begin
            it.action = ACTION_W'($urandom_range(3));
            if ($urandom_range(1) == 1)
                it.time_ms = $urandom();
        end
        return it;
    endfunction

    task automatic run_phase(
        input logic [CFG_W-1:0] delay,
        input logic [CFG_W-1:0] period,
        input int               src_pct,
        input int               sink_pct
    );
        wait_idle();
        write_config(delay, period);
        src_idle_pct = src_pct;
        sink_stall_pct <= sink_pct;
        repeat (PHASE_ITEMS) send_item(next_random_item());
    endtask

    initial begin
        rst_n                = 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.action        <= ACT_REPORT;
        req_ch.time_ms       <= '0;
        req_ch.modifier_bits <= '0;
        req_ch.key_count     <= '0;
        req_ch.key_a         <= '0;
        req_ch.key_b         <= '0;
        req_ch.key_c         <= '0;
        req_ch.key_d         <= '0;
        req_ch.key_e         <= '0;
        req_ch.key_f         <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.reg_index     <= CFG_REPEAT_DELAY;
        cfg_ch.data          <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, reset timing (500 ms delay, 70 ms period) ----
        // empty map right after reset
        send_item(pack_item(ACT_QUERY, 32'd0, 8'h00, 3'd0, 48'h00));
        // full report, all modifiers: six presses filling slots 7 down to 2
        send_item(pack_item(ACT_REPORT, 32'd1000, 8'hFF, 3'd6,
                            {8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04}));
        send_item(pack_item(ACT_QUERY, 32'd0, 8'h00, 3'd0, 48'h04));
        send_item(pack_item(ACT_QUERY, 32'd0, 8'h00, 3'd0, 48'hFF));
        // deadline 1500: equal is not due, one past is
        send_item(pack_item(ACT_TICK, 32'd1500, 8'h00, 3'd0, 48'h00));
        send_item(pack_item(ACT_TICK, 32'd1501, 8'h00, 3'd0, 48'h00));
        send_item(pack_item(ACT_TICK, 32'd1571, 8'h00, 3'd0, 48'h00));
        send_item(pack_item(ACT_TICK, 32'd1572, 8'h00, 3'd0, 48'h00));
        // count of seven is clamped; 0x09 released, 0x0A reuses its slot
        send_item(pack_item(ACT_REPORT, 32'd1600, 8'h00, 3'd7,
                            {8'h0A, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04}));
        // duplicate code in one report, Ctrl-Alt-Alt modifiers with Delete
        send_item(pack_item(ACT_REPORT, 32'd2000, 8'h45, 3'd6,
                            {8'h00, 8'h00, 8'h4C, 8'h0C, 8'h0B, 8'h0B}));
        send_item(pack_item(ACT_QUERY, 32'd0, 8'h00, 3'd0, 48'h0B));
        // empty report with junk past the count: all released, map cleared
        send_item(pack_item(ACT_REPORT, 32'd2100, 8'h00, 3'd0,
                            {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}));
        send_item(pack_item(ACT_QUERY, 32'd0, 8'h00, 3'd0, 48'hFF));
        // recent slot is free now: no repeat however late
        send_item(pack_item(ACT_TICK, 32'd9000, 8'h00, 3'd0, 48'h00));
        // unused action code
        send_item(pack_item(ACT_NOP, 32'hFFFF_FFFF, 8'hFF, 3'd7, 48'hFFFF_FFFF_FFFF));
        // deadline wraps past 2^32: repeats at once, and again once the period has passed
        send_item(pack_item(ACT_REPORT, 32'hFFFF_FF00, 8'h00, 3'd1, 48'hFF));
        send_item(pack_item(ACT_TICK, 32'hFFFF_FF01, 8'h00, 3'd0, 48'h00));
        send_item(pack_item(ACT_TICK, 32'hFFFF_FFFF, 8'h00, 3'd0, 48'h00));
        send_item(pack_item(ACT_QUERY, 32'd0, 8'h00, 3'd0, 48'hFF));
        send_item(pack_item(ACT_QUERY, 32'd0, 8'h00, 3'd0, 48'h00));

        // ---- random part: one timing setting and pacing mix per phase ----
        clock_ms = 32'd3000;
        run_phase(16'd0, 16'd0, 0, 0);
        run_phase(16'hFFFF, 16'hFFFF, 62, 0);
        run_phase(CFG_W'($urandom_range(40)), CFG_W'($urandom_range(20)), 0, 62);
        run_phase(CFG_W'($urandom()), CFG_W'($urandom()), 17, 17);
        run_phase(CFG_W'($urandom_range(10, 1)), 16'd1, 0, 0);

        // drain and let the block settle before the verdict
        wait_idle();
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
